FILE: rtl/mtf_pkg.sv
package mtf_pkg;

  localparam int OP_W  = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_INIT = 2'd1,
    PTR_STEP = 2'd2,
    PTR_INC  = 2'd3
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_POS = 2'd0,
    RD_PTR = 2'd1,
    RD_SRC = 2'd2
  } rd_sel_t;

  typedef enum logic {
    WR_MOVE = 1'b0,
    WR_PUT  = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    load_err;
    ptr_op_t ptr_op;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    found_set;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic move_more;
    logic scan_end;
    logic match;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/mtf_if.sv
interface mtf_req_if;
  import mtf_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [POS_W-1:0]   position;
  logic [VAL_W-1:0]   value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink (input valid, opcode, position, value, output ready);
endinterface

interface mtf_rsp_if;
  import mtf_pkg::*;

  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic [POS_W-1:0]   found_position;
  logic               error;
  logic [CNT_W-1:0]   count;

  modport source (output valid, read_value, found_position, error, count, input ready);
  modport sink (input valid, read_value, found_position, error, count, output ready);
endinterface

FILE: rtl/mtf_ram.sv
module mtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mtf_ctrl.sv
module mtf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  mtf_pkg::status_t status,
  output mtf_pkg::cmd_t    cmd
);
  import mtf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_SRD    = 8'b0000_0100,
    S_SCMP   = 8'b0000_1000,
    S_MRD    = 8'b0001_0000,
    S_MWR    = 8'b0010_0000,
    S_PUT    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.rd_sel = RD_POS;
    cmd.wr_sel = WR_MOVE;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.load_err = 1'b1;
        cmd.ptr_op   = PTR_INIT;
        if (status.err || status.op == OP_READ) begin
          state_next = S_DONE;
        end else if (status.op == OP_SEARCH) begin
          state_next = S_SRD;
        end else begin
          state_next = S_MRD;
        end
      end
      S_SRD: begin
        if (status.scan_end) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_sel = RD_PTR;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (status.match) begin
          cmd.found_set = 1'b1;
          state_next    = S_MRD;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_SRD;
        end
      end
      S_MRD: begin
        if (status.move_more) begin
          cmd.rd_sel = RD_SRC;
          state_next = S_MWR;
        end else if (status.op == OP_REMOVE) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          state_next = S_PUT;
        end
      end
      S_MWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MOVE;
        cmd.ptr_op = PTR_STEP;
        state_next = S_MRD;
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_PUT;
        cmd.cnt_inc = (status.op == OP_INSERT);
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/mtf_dpath.sv
module mtf_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mtf_pkg::cmd_t               cmd,
  output mtf_pkg::status_t            status,
  input  logic [mtf_pkg::OP_W-1:0]    opcode,
  input  logic [mtf_pkg::POS_W-1:0]   position,
  input  logic [mtf_pkg::VAL_W-1:0]   value,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [mtf_pkg::VAL_W-1:0]   read_value,
  output logic [mtf_pkg::POS_W-1:0]   found_position,
  output logic                        error,
  output logic [mtf_pkg::CNT_W-1:0]   count
);
  import mtf_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // compare width: holds count+1 and any position
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  op_t               op_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic              err_r;
  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     entry_count_next;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     ptr_next;
  logic [POS_W-1:0]  found;

  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     ptr_x;
  logic [XW-1:0]     pos_m1_x;
  logic [XW-1:0]     ptr_p1_x;
  logic [CW-1:0]     ptr_m1;
  logic              fwd;
  logic              ins_bad;
  logic              idx_bad;
  logic [XW-1:0]     lo_x;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(entry_count);
  assign ptr_x    = XW'(ptr);
  assign pos_m1_x = pos_x - XW'(1);
  assign ptr_p1_x = ptr_x + XW'(1);
  assign ptr_m1   = ptr - CW'(1);
  assign fwd      = (op_r == OP_REMOVE);

  assign ins_bad = (pos_r == '0) || (pos_x > cnt_x + XW'(1)) || (cnt_x >= XW'(CAPACITY));
  assign idx_bad = (pos_r == '0) || (pos_x > cnt_x);
  assign lo_x    = (op_r == OP_INSERT) ? pos_x : XW'(1);

  always_comb begin
    status.op        = op_r;
    case (op_r)
      OP_INSERT:           status.err = ins_bad;
      OP_READ, OP_REMOVE:  status.err = idx_bad;
      default:             status.err = 1'b0;
    endcase
    status.move_more = fwd ? (ptr_x < cnt_x) : (ptr_x >= lo_x);
    status.scan_end  = (ptr_x >= cnt_x);
    status.match     = (ram_rdata == val_r);
    status.out_free  = !rsp_valid || rsp_ready;
  end

  // pointer: start point per operation, then walks the list
  always_comb begin
    ptr_next = ptr;
    case (cmd.ptr_op)
      PTR_INIT: begin
        case (op_r)
          OP_INSERT: ptr_next = entry_count;
          OP_REMOVE: ptr_next = pos_x[CW-1:0];
          default:   ptr_next = '0;
        endcase
      end
      PTR_STEP: ptr_next = fwd ? ptr_p1_x[CW-1:0] : ptr_m1;
      PTR_INC:  ptr_next = ptr_p1_x[CW-1:0];
      default:  ptr_next = ptr;
    endcase
  end

  always_comb begin
    entry_count_next = entry_count;
    if (cmd.cnt_inc) begin
      entry_count_next = entry_count + CW'(1);
    end else if (cmd.cnt_dec) begin
      entry_count_next = entry_count - CW'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:  ram_raddr = ptr[AW-1:0];
      RD_SRC:  ram_raddr = fwd ? ptr[AW-1:0] : ptr_m1[AW-1:0];
      default: ram_raddr = pos_m1_x[AW-1:0];
    endcase
  end

  always_comb begin
    ram_we = cmd.wr_en;
    if (cmd.wr_sel == WR_PUT) begin
      ram_waddr = (op_r == OP_INSERT) ? pos_m1_x[AW-1:0] : '0;
      ram_wdata = val_r;
    end else begin
      ram_waddr = fwd ? ptr_m1[AW-1:0] : ptr[AW-1:0];
      ram_wdata = ram_rdata;
    end
  end

  mtf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      ptr         <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      ptr         <= ptr_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= op_t'(opcode);
      pos_r <= position;
      val_r <= value;
      found <= '0;
    end
    if (cmd.load_err) begin
      err_r <= status.err;
    end
    if (cmd.found_set) begin
      found <= ptr_p1_x[POS_W-1:0];
    end
    // rdata still holds the entry at pos-1 for a read
    if (cmd.out_load) begin
      read_value     <= (op_r == OP_READ && !err_r) ? ram_rdata : '0;
      found_position <= found;
      error          <= err_r;
      count          <= cnt_x[CNT_W-1:0];
    end
  end

endmodule

FILE: rtl/move_to_front_list.sv
// With n = entries before the op: a read or a refused op moves no entries; an insert at p
// moves the n-p+1 entries from p on back, a remove at p moves the n-p entries after p forward;
// a search scans from the head; on a hit at k the k-1 entries ahead shift back and it goes first.
// One request at a time: the next beat is taken once the result sits in the output register.
// Each list move is a read then a write on the entry RAM.
// Reset (rst, synchronous) empties the list; entry storage is not cleared, no clearing pass.
module move_to_front_list #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  mtf_req_if.sink   req,
  mtf_rsp_if.source rsp
);
  import mtf_pkg::*;

  cmd_t    cmd;
  status_t status;

  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mtf_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (req.opcode),
    .position       (req.position),
    .value          (req.value),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .read_value     (rsp.read_value),
    .found_position (rsp.found_position),
    .error          (rsp.error),
    .count          (rsp.count)
  );

endmodule

FILE: rtl/mtf_checker.sv
module mtf_checker #(
  parameter int CAPACITY = 16
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [mtf_pkg::VAL_W-1:0] read_value,
  input logic [mtf_pkg::POS_W-1:0] found_position,
  input logic                      error,
  input logic [mtf_pkg::CNT_W-1:0] count
);
  import mtf_pkg::*;

  // result beat holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(count) && $stable(error))
    else $error("result beat dropped or changed while stalled");

  // one request in flight: intake closes right after a beat
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error |-> found_position == '0 && read_value == '0)
    else $error("refused op returned data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CAPACITY > 31) || (32'(count) <= 32'(CAPACITY)))
    else $error("count above capacity");

  a_found_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found_position != '0 |-> !error && ((CAPACITY > 31) || found_position <= count))
    else $error("found position beyond list");

endmodule

bind move_to_front_list mtf_checker #(
  .CAPACITY (CAPACITY)
) u_mtf_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .read_value     (rsp.read_value),
  .found_position (rsp.found_position),
  .error          (rsp.error),
  .count          (rsp.count)
);
